FILE: src/bdlp_pkg.sv
`default_nettype none
package bdlp_pkg;

	// Default width of the tick counter and every stored time stamp.
	localparam int TIME_BITS_DEF = 32;

	// Configuration port geometry.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;
	localparam int DEB_W      = 16;
	localparam int THR_W      = 32;
	localparam int HOLD_OUT_W = 32;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B_LONG   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_C_LONG   = 2'd2;

	// Register reset values.
	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [THR_W-1:0] B_LONG_RST   = 32'd1000;
	localparam logic [THR_W-1:0] C_LONG_RST   = 32'd5000;

	// Flag positions in the event word and in clear_mask.
	localparam int FLAG_W      = 5;
	localparam int FLAG_A      = 0;
	localparam int FLAG_BSHORT = 1;
	localparam int FLAG_BLONG  = 2;
	localparam int FLAG_CSHORT = 3;
	localparam int FLAG_CLONG  = 4;

	// What a debounce lane decided for the current tick.
	typedef struct packed {
		logic changed;   // a new level was accepted this tick
		logic level;     // accepted level after this tick
	} db_res_t;

	// What a hold lane found for the current tick.
	typedef struct packed {
		logic short_hit; // released before the long threshold
		logic long_hit;  // long threshold reached this tick
		logic held;      // accepted level is low after this tick
	} hold_res_t;

endpackage
`default_nettype wire

FILE: src/bdlp_debounce.sv
`default_nettype none
module bdlp_debounce
	import bdlp_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 raw,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic [DEB_W-1:0]     debounce_ticks,
	output db_res_t                   res
);

	logic                 stable_q;
	logic [TIME_BITS-1:0] last_q;
	logic [TIME_BITS-1:0] since;

	// A change is taken only once the lockout since the last accepted change has run out.
	assign since       = now - last_q;
	assign res.changed = (raw != stable_q) && (since >= TIME_BITS'(debounce_ticks));
	assign res.level   = res.changed ? raw : stable_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stable_q <= 1'b1;
			last_q   <= '0;
		end else if (step && res.changed) begin
			stable_q <= raw;
			last_q   <= now;
		end
	end

endmodule
`default_nettype wire

FILE: src/bdlp_hold.sv
`default_nettype none
module bdlp_hold
	import bdlp_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 step,
	input  wire logic                 raw,
	input  wire logic [TIME_BITS-1:0] now,
	input  wire logic [DEB_W-1:0]     debounce_ticks,
	input  wire logic [THR_W-1:0]     long_ticks,
	output hold_res_t                 res,
	output logic      [TIME_BITS-1:0] hold
);

	localparam int CMP_W = (TIME_BITS > THR_W) ? TIME_BITS : THR_W;

	db_res_t              db;
	logic [TIME_BITS-1:0] start_q;
	logic                 fired_q;
	logic                 press_now;
	logic                 fired_n;
	logic [TIME_BITS-1:0] elapsed;
	logic [TIME_BITS-1:0] elapsed_new;
	logic [CMP_W-1:0]     thr_ext;
	logic                 below_old;
	logic                 below_new;

	bdlp_debounce #(
		.TIME_BITS(TIME_BITS)
	) u_db (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (step),
		.raw           (raw),
		.now           (now),
		.debounce_ticks(debounce_ticks),
		.res           (db)
	);

	assign thr_ext     = CMP_W'(long_ticks);
	assign elapsed     = now - start_q;
	assign below_old   = CMP_W'(elapsed) < thr_ext;
	assign press_now   = db.changed && !db.level;
	// A fresh press restarts the hold at zero.
	assign elapsed_new = press_now ? '0 : elapsed;
	assign below_new   = CMP_W'(elapsed_new) < thr_ext;
	assign fired_n     = press_now ? 1'b0 : fired_q;

	assign res.short_hit = db.changed && db.level && !fired_q && below_old;
	assign res.long_hit  = !db.level && !fired_n && !below_new;
	assign res.held      = !db.level;
	assign hold          = db.level ? '0 : elapsed_new;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= '0;
			fired_q <= 1'b0;
		end else if (step) begin
			if (press_now) begin
				start_q <= now;
			end
			fired_q <= fired_n || res.long_hit;
		end
	end

endmodule
`default_nettype wire

FILE: src/button_debounce_long_press_top.sv
`default_nettype none
// Channel  Direction  Handshake              Carries
// in       request    in_valid / in_ready    level_a, level_b, level_c, clear_mask
// out      result     out_valid / out_ready  a_press .. c_long, c_hold_ticks
// cfg      request    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Every request is one tick and is finished in the cycle it is accepted; its result
// appears in the output register on the next cycle, so a request may follow every clock.
// The figure is set by the combinational lane update: one subtract and compare for the
// lockout in each lane and one for the hold time in lanes B and C, then the flag merge.
// Reset sets all buttons released, all flags clear, time zero and the default registers.
// A result waiting in the output register blocks a new request only while out_ready is low.
module button_debounce_long_press_top
	import bdlp_pkg::*;
#(
	parameter int TIME_BITS = TIME_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic                  level_a,
	input  wire logic                  level_b,
	input  wire logic                  level_c,
	input  wire logic [FLAG_W-1:0]     clear_mask,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic                       a_press,
	output logic                       b_short,
	output logic                       b_long,
	output logic                       c_short,
	output logic                       c_long,
	output logic [HOLD_OUT_W-1:0]      c_hold_ticks,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int WIDE_W = (TIME_BITS > HOLD_OUT_W) ? TIME_BITS : HOLD_OUT_W;

	logic                  in_acc;
	logic [DEB_W-1:0]      deb_q;
	logic [THR_W-1:0]      b_thr_q;
	logic [THR_W-1:0]      c_thr_q;
	logic [TIME_BITS-1:0]  tick_q;
	logic [FLAG_W-1:0]     flags_q;
	logic [FLAG_W-1:0]     flags_next;
	logic                  out_valid_q;
	logic [FLAG_W-1:0]     out_flags_q;
	logic [HOLD_OUT_W-1:0] out_hold_q;
	db_res_t               a_res;
	hold_res_t             b_res;
	hold_res_t             c_res;
	logic [TIME_BITS-1:0]  b_hold;
	logic [TIME_BITS-1:0]  c_hold;

	// The block takes a request whenever the output register is empty or being emptied.
	assign in_ready  = !out_valid_q || out_ready;
	assign in_acc    = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Configuration registers; an index beyond the list is simply dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deb_q   <= DEBOUNCE_RST;
			b_thr_q <= B_LONG_RST;
			c_thr_q <= C_LONG_RST;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_DEBOUNCE: deb_q   <= cfg_data[DEB_W-1:0];
				REG_B_LONG:   b_thr_q <= cfg_data[THR_W-1:0];
				REG_C_LONG:   c_thr_q <= cfg_data[THR_W-1:0];
				default: ;
			endcase
		end
	end

	// Button A only needs the debounce; its press is the accepted falling level.
	bdlp_debounce #(
		.TIME_BITS(TIME_BITS)
	) u_lane_a (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (in_acc),
		.raw           (level_a),
		.now           (tick_q),
		.debounce_ticks(deb_q),
		.res           (a_res)
	);

	// Buttons B and C run the full short and long press lane, each with its own threshold.
	bdlp_hold #(
		.TIME_BITS(TIME_BITS)
	) u_lane_b (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (in_acc),
		.raw           (level_b),
		.now           (tick_q),
		.debounce_ticks(deb_q),
		.long_ticks    (b_thr_q),
		.res           (b_res),
		.hold          (b_hold)
	);

	bdlp_hold #(
		.TIME_BITS(TIME_BITS)
	) u_lane_c (
		.clk           (clk),
		.arst_n        (arst_n),
		.step          (in_acc),
		.raw           (level_c),
		.now           (tick_q),
		.debounce_ticks(deb_q),
		.long_ticks    (c_thr_q),
		.res           (c_res),
		.hold          (c_hold)
	);

	// Merge stage: the lanes' events are OR-ed into the sticky flags. The result shows
	// the flags before this tick's clear, so a flag raised and cleared in the same tick
	// is still reported once. Button B's hold time is not reported.
	always_comb begin
		flags_next              = flags_q;
		flags_next[FLAG_A]      = flags_q[FLAG_A]      | (a_res.changed & ~a_res.level);
		flags_next[FLAG_BSHORT] = flags_q[FLAG_BSHORT] | b_res.short_hit;
		flags_next[FLAG_BLONG]  = flags_q[FLAG_BLONG]  | (b_res.long_hit & b_res.held
			& (b_hold == b_hold));
		flags_next[FLAG_CSHORT] = flags_q[FLAG_CSHORT] | c_res.short_hit;
		flags_next[FLAG_CLONG]  = flags_q[FLAG_CLONG]  | (c_res.long_hit & c_res.held);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q  <= '0;
			flags_q <= '0;
		end else if (in_acc) begin
			tick_q  <= tick_q + 1'b1;
			flags_q <= flags_next & ~clear_mask;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_acc) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// The hold time is reported on 32 bits whatever the time width.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			out_flags_q <= flags_next;
			out_hold_q  <= HOLD_OUT_W'(WIDE_W'(c_hold));
		end
	end

	assign out_valid    = out_valid_q;
	assign a_press      = out_flags_q[FLAG_A];
	assign b_short      = out_flags_q[FLAG_BSHORT];
	assign b_long       = out_flags_q[FLAG_BLONG];
	assign c_short      = out_flags_q[FLAG_CSHORT];
	assign c_long       = out_flags_q[FLAG_CLONG];
	assign c_hold_ticks = out_hold_q;

	// Every accepted tick leaves a result behind it.
	assert property (@(posedge clk) disable iff (!arst_n) in_acc |=> out_valid_q)
		else $error("accepted tick produced no result");

	// Time advances by exactly one per accepted tick and holds otherwise.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> tick_q == $past(tick_q) + 1'b1)
		else $error("tick counter did not advance");

	assert property (@(posedge clk) disable iff (!arst_n) !in_acc |=> $stable(tick_q))
		else $error("tick counter moved without a tick");

	// A sticky flag can only survive a tick if that tick's result reported it.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (flags_q & ~out_flags_q) == '0)
		else $error("flag kept that was not reported");

	// A short and a long press of one button never arise in the same tick.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |-> !(c_res.short_hit && c_res.long_hit) && !(b_res.short_hit && b_res.long_hit))
		else $error("short and long press in one tick");

endmodule
`default_nettype wire
